>>> sv/touch_key_run_mode_control_core_macros.svh
// Assertion macros shared by the touch key run/mode control RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef TOUCH_KEY_RUN_MODE_CONTROL_CORE_MACROS_SVH
`define TOUCH_KEY_RUN_MODE_CONTROL_CORE_MACROS_SVH

// same-cycle implication
`define TKRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TKRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tkrm_pkg.sv
// Package for the touch key run/mode control core: widths, register codes,
// transaction payload types and key qualification state. No dependencies.
`timescale 1ns / 1ps

package tkrm_pkg;

	localparam int SENSE_BITS    = 16;
	localparam int COUNTER_BITS  = 8;
	localparam int NUM_THR       = 4;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [SENSE_BITS-1:0] THR_RESET     = '1;
	localparam logic [1:0]            RUN_LEN_LATCH = 2'd3;

	typedef enum logic [1:0] {
		REG_THR_CW   = 2'd0,
		REG_THR_CCW  = 2'd1,
		REG_THR_RUN  = 2'd2,
		REG_THR_MODE = 2'd3
	} reg_idx_t;

	typedef enum logic {
		KEY_RUN  = 1'b0,
		KEY_MODE = 1'b1
	} qual_key_t;

	typedef struct packed {
		logic [SENSE_BITS-1:0] sense_count_cw;
		logic [SENSE_BITS-1:0] sense_count_ccw;
		logic [SENSE_BITS-1:0] sense_count_run;
		logic [SENSE_BITS-1:0] sense_count_mode;
	} sense_item_t;

	typedef struct packed {
		logic                    motor_enable;
		logic                    motor_direction;
		logic                    led_cw;
		logic                    led_ccw;
		logic                    teaching_mode;
		logic                    running;
		logic                    save_request;
		logic                    clear_record_request;
		logic                    step_reset;
		logic [COUNTER_BITS-1:0] cw_tick_count;
		logic [COUNTER_BITS-1:0] ccw_tick_count;
		logic [COUNTER_BITS-1:0] idle_tick_count;
	} ctrl_item_t;

	typedef struct packed {
		logic       prev_released;
		logic       edge_seen;
		logic [1:0] run_len;
		logic       latched;
	} key_state_t;

endpackage

>>> sv/tkrm_if.sv
// Valid/ready channel interfaces for the touch key run/mode control core.
// Depends on tkrm_pkg for the payload types.
`timescale 1ns / 1ps

interface tkrm_sense_if;
	import tkrm_pkg::*;
	logic        valid;
	logic        ready;
	sense_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tkrm_ctrl_if;
	import tkrm_pkg::*;
	logic       valid;
	logic       ready;
	ctrl_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/touch_key_run_mode_control_core.sv
// Touch key run/mode control core: one sense tick in, one control result out.
// One transaction per cycle sustained: an input register feeds the key
// compare, press qualification, mode and motor logic, which loads a result register. The
// result register frees itself while the sink takes it, so a stalled sink holds both stages
// and no transaction is lost. Thresholds sit behind an APB port at 0x0, 0x4, 0x8, 0xC.
// Depends on tkrm_pkg, tkrm_if and the assertion macro header.
`timescale 1ns / 1ps
`include "touch_key_run_mode_control_core_macros.svh"

module touch_key_run_mode_control_core (
	input  logic                               clk,
	input  logic                               arst_n,
	tkrm_sense_if.sink                         sense,
	tkrm_ctrl_if.source                        control,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tkrm_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [tkrm_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [tkrm_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import tkrm_pkg::*;

	logic [SENSE_BITS-1:0] thr_q [NUM_THR];
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	logic                  valid_s1;
	sense_item_t           item_s1;
	logic                  advance;

	logic                  out_valid_q;
	ctrl_item_t            result_q;
	ctrl_item_t            result_d;

	key_state_t            key_q [2];
	key_state_t            key_d [2];
	logic                  teach_q, teach_d;
	logic                  run_q, run_d;
	logic [COUNTER_BITS-1:0] cw_q, ccw_q, idle_q;
	logic [COUNTER_BITS-1:0] cw_d, ccw_d, idle_d;
	logic                  save_d, clr_d, stp_d;
	logic                  t_cw, t_ccw, t_run, t_mode;

	function automatic key_state_t qualify(key_state_t s, logic touched);
		key_state_t n;
		n = s;
		if (touched) begin
			if (s.prev_released) begin
				n.edge_seen = 1'b1;
				n.run_len   = 2'd1;
			end else if (s.edge_seen) begin
				if (s.run_len == RUN_LEN_LATCH) begin
					n.latched   = 1'b1;
					n.edge_seen = 1'b0;
				end else begin
					n.run_len = s.run_len + 2'd1;
				end
			end
		end else begin
			n.run_len = 2'd0;
		end
		n.prev_released = !touched;
		return n;
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = APB_DATA_BITS'(thr_q[reg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THR; i++) thr_q[i] <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q[reg_idx] <= pwdata[SENSE_BITS-1:0];
		end
	end

	// handshake
	assign advance     = valid_s1 && (!out_valid_q || control.ready);
	assign sense.ready = !valid_s1 || advance;
	assign control.valid   = out_valid_q;
	assign control.payload = result_q;

	always_ff @(posedge clk) begin
		if (sense.valid && sense.ready) begin
			item_s1 <= sense.payload;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	// tick logic
	always_comb begin
		t_cw   = item_s1.sense_count_cw   > thr_q[REG_THR_CW];
		t_ccw  = item_s1.sense_count_ccw  > thr_q[REG_THR_CCW];
		t_run  = item_s1.sense_count_run  > thr_q[REG_THR_RUN];
		t_mode = item_s1.sense_count_mode > thr_q[REG_THR_MODE];

		key_d[KEY_RUN]  = qualify(key_q[KEY_RUN], t_run);
		key_d[KEY_MODE] = qualify(key_q[KEY_MODE], t_mode);

		teach_d = teach_q;
		run_d   = run_q;
		save_d  = 1'b0;
		clr_d   = 1'b0;
		stp_d   = 1'b0;
		if (key_d[KEY_MODE].latched) begin
			save_d  = teach_q;
			teach_d = !teach_q;
			run_d   = 1'b0;
			key_d[KEY_MODE].latched = 1'b0;
		end else if (key_d[KEY_RUN].latched) begin
			run_d = !run_q;
			clr_d = !run_q && teach_q;
			stp_d = !run_q && !teach_q;
			key_d[KEY_RUN].latched = 1'b0;
		end

		cw_d   = cw_q;
		ccw_d  = ccw_q;
		idle_d = idle_q;
		if (t_cw) begin
			cw_d = cw_q + COUNTER_BITS'(1);
		end else if (t_ccw) begin
			ccw_d = ccw_q + COUNTER_BITS'(1);
		end else begin
			idle_d = idle_q + COUNTER_BITS'(1);
		end

		result_d.motor_enable         = t_cw || t_ccw;
		result_d.motor_direction      = !t_cw && t_ccw;
		result_d.led_cw               = t_cw;
		result_d.led_ccw              = t_ccw;
		result_d.teaching_mode        = teach_d;
		result_d.running              = run_d;
		result_d.save_request         = save_d;
		result_d.clear_record_request = clr_d;
		result_d.step_reset           = stp_d;
		result_d.cw_tick_count        = cw_d;
		result_d.ccw_tick_count       = ccw_d;
		result_d.idle_tick_count      = idle_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			key_q[0]    <= '0;
			key_q[1]    <= '0;
			teach_q     <= 1'b0;
			run_q       <= 1'b0;
			cw_q        <= '0;
			ccw_q       <= '0;
			idle_q      <= '0;
		end else begin
			if (sense.ready) begin
				valid_s1 <= sense.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				key_q[0]    <= key_d[0];
				key_q[1]    <= key_d[1];
				teach_q     <= teach_d;
				run_q       <= run_d;
				cw_q        <= cw_d;
				ccw_q       <= ccw_d;
				idle_q      <= idle_d;
			end else if (control.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TKRM_ASSERT_NOW(a_dir_needs_enable, out_valid_q && result_q.motor_direction, result_q.motor_enable, "ccw direction without enable")
	`TKRM_ASSERT_NOW(a_one_pulse, out_valid_q, $onehot0({result_q.save_request, result_q.clear_record_request, result_q.step_reset}), "more than one request pulse")
	`TKRM_ASSERT_NOW(a_save_state, out_valid_q && result_q.save_request, !result_q.teaching_mode && !result_q.running, "save request with wrong mode")
	`TKRM_ASSERT_NOW(a_start_state, out_valid_q && (result_q.clear_record_request || result_q.step_reset), result_q.running && (result_q.teaching_mode == result_q.clear_record_request), "run start pulse with wrong mode")
	`TKRM_ASSERT_NEXT(a_one_counter, advance, COUNTER_BITS'(cw_q + ccw_q + idle_q) == COUNTER_BITS'($past(cw_q + ccw_q + idle_q) + COUNTER_BITS'(1)), "tick counters did not advance by one")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for touch_key_run_mode_control_core: threshold registers over APB, sense ticks in,
// control results checked field by field against an in-bench model of keys, mode and motor.
// Depends on tkrm_pkg, tkrm_if and the core RTL.

module tb;
	import tkrm_pkg::*;

	typedef enum int {
		RX_FREE,
		RX_HALF,
		RX_SPARSE,
		RX_BLOCK
	} rx_mode_t;

	localparam int                    DRAIN_CYCLES = 6;
	localparam logic [SENSE_BITS-1:0] SENSE_MAX    = '1;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	tkrm_sense_if sense_ch ();
	tkrm_ctrl_if  ctrl_ch ();

	touch_key_run_mode_control_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sense   (sense_ch.sink),
		.control (ctrl_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model state
	logic [SENSE_BITS-1:0]   thr_model [NUM_THR];
	key_state_t              key_model [2];
	logic                    teach_model;
	logic                    run_model;
	logic [COUNTER_BITS-1:0] cw_cnt_model;
	logic [COUNTER_BITS-1:0] ccw_cnt_model;
	logic [COUNTER_BITS-1:0] idle_cnt_model;

	ctrl_item_t pending_ctrl_q [$];
	int         error_count;
	bit         gaps_on;
	int         burst_left;
	int         press_left [2];
	bit         press_touch [2];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic key_state_t qualify_key(key_state_t ks, logic touched);
		if (touched) begin
			if (ks.prev_released) begin
				ks.edge_seen = 1'b1;
				ks.run_len   = 2'd1;
			end else if (ks.edge_seen) begin
				if (ks.run_len == RUN_LEN_LATCH) begin
					ks.latched   = 1'b1;
					ks.edge_seen = 1'b0;
				end else begin
					ks.run_len = ks.run_len + 2'd1;
				end
			end
		end else begin
			ks.run_len = '0;
		end
		ks.prev_released = !touched;
		return ks;
	endfunction

	function automatic ctrl_item_t compute_ctrl_outputs(sense_item_t it);
		ctrl_item_t r;
		logic       t_cw;
		logic       t_ccw;
		logic       t_run;
		logic       t_mode;
		t_cw   = it.sense_count_cw > thr_model[REG_THR_CW];
		t_ccw  = it.sense_count_ccw > thr_model[REG_THR_CCW];
		t_run  = it.sense_count_run > thr_model[REG_THR_RUN];
		t_mode = it.sense_count_mode > thr_model[REG_THR_MODE];
		key_model[KEY_RUN]  = qualify_key(key_model[KEY_RUN], t_run);
		key_model[KEY_MODE] = qualify_key(key_model[KEY_MODE], t_mode);
		r = '0;
		// mode press wins; a run press latched alongside waits one tick
		if (key_model[KEY_MODE].latched) begin
			if (teach_model) begin
				teach_model    = 1'b0;
				r.save_request = 1'b1;
			end else begin
				teach_model = 1'b1;
			end
			run_model                   = 1'b0;
			key_model[KEY_MODE].latched = 1'b0;
		end else if (key_model[KEY_RUN].latched) begin
			if (!run_model) begin
				run_model = 1'b1;
				if (teach_model)
					r.clear_record_request = 1'b1;
				else
					r.step_reset = 1'b1;
			end else begin
				run_model = 1'b0;
			end
			key_model[KEY_RUN].latched = 1'b0;
		end
		if (t_cw) begin
			r.motor_enable = 1'b1;
			cw_cnt_model   = cw_cnt_model + COUNTER_BITS'(1);
		end else if (t_ccw) begin
			r.motor_enable    = 1'b1;
			r.motor_direction = 1'b1;
			ccw_cnt_model     = ccw_cnt_model + COUNTER_BITS'(1);
		end else begin
			idle_cnt_model = idle_cnt_model + COUNTER_BITS'(1);
		end
		r.led_cw          = t_cw;
		r.led_ccw         = t_ccw;
		r.teaching_mode   = teach_model;
		r.running         = run_model;
		r.cw_tick_count   = cw_cnt_model;
		r.ccw_tick_count  = ccw_cnt_model;
		r.idle_tick_count = idle_cnt_model;
		return r;
	endfunction

	function automatic logic [SENSE_BITS-1:0] count_for(reg_idx_t idx, bit touched);
		logic [SENSE_BITS-1:0] t;
		t = thr_model[idx];
		if (touched && t != SENSE_MAX)
			return SENSE_BITS'($urandom_range(32'hFFFF, 32'(t) + 32'd1));
		else if (!touched)
			return SENSE_BITS'($urandom_range(32'(t), 0));
		return SENSE_BITS'($urandom());
	endfunction

	function automatic sense_item_t keys_tick(bit cw, bit ccw, bit run, bit mode);
		sense_item_t it;
		it.sense_count_cw   = count_for(REG_THR_CW, cw);
		it.sense_count_ccw  = count_for(REG_THR_CCW, ccw);
		it.sense_count_run  = count_for(REG_THR_RUN, run);
		it.sense_count_mode = count_for(REG_THR_MODE, mode);
		return it;
	endfunction

	// mostly well-formed release/touch runs on the qualified keys, plus noise
	function automatic sense_item_t random_tick();
		sense_item_t it;
		int          pick;
		for (int k = 0; k < 2; k++) begin
			if (press_left[k] == 0) begin
				press_touch[k] = !press_touch[k];
				press_left[k]  = press_touch[k] ? $urandom_range(7, 1) : $urandom_range(3, 1);
			end
			press_left[k]--;
		end
		pick = $urandom_range(3);
		it   = keys_tick(pick[0], pick[1], press_touch[KEY_RUN], press_touch[KEY_MODE]);
		if ($urandom_range(3) == 0)
			it.sense_count_cw = SENSE_BITS'($urandom());
		if ($urandom_range(3) == 0)
			it.sense_count_ccw = SENSE_BITS'($urandom());
		if ($urandom_range(9) == 0)
			it.sense_count_run = SENSE_BITS'($urandom());
		if ($urandom_range(9) == 0)
			it.sense_count_mode = SENSE_BITS'($urandom());
		return it;
	endfunction

	task automatic send_tick(input sense_item_t it);
		int gap;
		gap = 0;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap        = $urandom_range(7, 1);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			sense_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sense_ch.valid   <= 1'b1;
		sense_ch.payload <= it;
		do @(posedge clk); while (sense_ch.ready !== 1'b1);
		pending_ctrl_q.push_back(compute_ctrl_outputs(it));
	endtask

	task automatic drain_pipeline;
		@(negedge clk);
		sense_ch.valid <= 1'b0;
		while (pending_ctrl_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input reg_idx_t idx,
			input logic [APB_DATA_BITS-1:0] wdata, output logic [APB_DATA_BITS-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_threshold_reg(input reg_idx_t idx);
		logic [APB_DATA_BITS-1:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== APB_DATA_BITS'(thr_model[idx])) begin
			$display("%0t readback %s: expected %0h, actual %0h", $time, idx.name(),
				APB_DATA_BITS'(thr_model[idx]), rd);
			error_count++;
		end
	endtask

	task automatic set_threshold(input reg_idx_t idx, input logic [SENSE_BITS-1:0] value);
		logic [APB_DATA_BITS-1:0] rd;
		apb_xfer(1'b1, idx, APB_DATA_BITS'(value), rd);
		thr_model[idx] = value;
		check_threshold_reg(idx);
	endtask

	task automatic set_random_thresholds;
		for (int i = 0; i < NUM_THR; i++)
			set_threshold(reg_idx_t'(i), SENSE_BITS'($urandom()));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic check_ctrl(input ctrl_item_t want, input ctrl_item_t got);
		check_field("motor_enable", 32'(want.motor_enable), 32'(got.motor_enable));
		check_field("motor_direction", 32'(want.motor_direction),
			32'(got.motor_direction));
		check_field("led_cw", 32'(want.led_cw), 32'(got.led_cw));
		check_field("led_ccw", 32'(want.led_ccw), 32'(got.led_ccw));
		check_field("teaching_mode", 32'(want.teaching_mode), 32'(got.teaching_mode));
		check_field("running", 32'(want.running), 32'(got.running));
		check_field("save_request", 32'(want.save_request), 32'(got.save_request));
		check_field("clear_record_request", 32'(want.clear_record_request),
			32'(got.clear_record_request));
		check_field("step_reset", 32'(want.step_reset), 32'(got.step_reset));
		check_field("cw_tick_count", 32'(want.cw_tick_count), 32'(got.cw_tick_count));
		check_field("ccw_tick_count", 32'(want.ccw_tick_count),
			32'(got.ccw_tick_count));
		check_field("idle_tick_count", 32'(want.idle_tick_count),
			32'(got.idle_tick_count));
	endtask

	always @(posedge clk) begin
		ctrl_item_t want;
		if (arst_n && ctrl_ch.valid === 1'b1 && ctrl_ch.ready === 1'b1) begin
			if (pending_ctrl_q.size() == 0) begin
				$display("%0t unexpected control transaction: expected none, actual %p",
					$time, ctrl_ch.payload);
				error_count++;
			end else begin
				want = pending_ctrl_q.pop_front();
				check_ctrl(want, ctrl_ch.payload);
			end
		end
	end

	// result sink stall pattern
	initial begin
		rx_mode_t m;
		int       seg;
		ctrl_ch.ready = 1'b0;
		forever begin
			m   = rx_mode_t'($urandom_range(3));
			seg = (m == RX_BLOCK) ? $urandom_range(12, 2) : $urandom_range(40, 4);
			repeat (seg) begin
				@(negedge clk);
				case (m)
					RX_FREE:   ctrl_ch.ready <= 1'b1;
					RX_HALF:   ctrl_ch.ready <= 1'($urandom_range(1));
					RX_SPARSE: ctrl_ch.ready <= ($urandom_range(3) == 0);
					default:   ctrl_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	task automatic test_reset_values;
		for (int i = 0; i < NUM_THR; i++)
			check_threshold_reg(reg_idx_t'(i));
		send_tick(sense_item_t'{SENSE_MAX, SENSE_MAX, SENSE_MAX, SENSE_MAX});
	endtask

	task automatic test_threshold_edges;
		drain_pipeline();
		set_threshold(REG_THR_CW, '0);
		set_threshold(REG_THR_CCW, SENSE_MAX - SENSE_BITS'(1));
		set_threshold(REG_THR_RUN, '0);
		set_threshold(REG_THR_MODE, '0);
		send_tick(sense_item_t'{16'h0000, SENSE_MAX, 16'h0000, 16'h0000});
		send_tick(sense_item_t'{16'h0001, SENSE_MAX - SENSE_BITS'(1), 16'h0000, 16'h0000});
		send_tick(sense_item_t'{SENSE_MAX, SENSE_MAX, 16'h0000, 16'h0000});
		send_tick(sense_item_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
	endtask

	// run and mode thresholds are still 0 from the edge test
	task automatic test_press_qualification;
		send_tick(keys_tick(1, 0, 1, 0));
		send_tick(keys_tick(0, 1, 0, 0));
		repeat (4) send_tick(keys_tick(0, 0, 1, 0));
		send_tick(keys_tick(1, 1, 1, 0));
		repeat (4) send_tick(keys_tick(0, 1, 0, 1));
		repeat (4) send_tick(keys_tick(1, 0, 1, 0));
		send_tick(keys_tick(0, 0, 0, 0));
		repeat (4) send_tick(keys_tick(0, 0, 1, 1));
		send_tick(keys_tick(1, 0, 0, 0));
	endtask

	task automatic test_random_traffic;
		drain_pipeline();
		set_random_thresholds();
		gaps_on = 1'b1;
		repeat (175) send_tick(random_tick());
		drain_pipeline();
		set_random_thresholds();
		repeat (175) send_tick(random_tick());
	endtask

	task automatic test_back_to_back;
		drain_pipeline();
		set_random_thresholds();
		gaps_on = 1'b0;
		repeat (175) send_tick(random_tick());
	endtask

	task automatic test_extreme_thresholds;
		drain_pipeline();
		set_threshold(REG_THR_CW, SENSE_MAX);
		set_threshold(REG_THR_CCW, '0);
		set_threshold(REG_THR_RUN, '0);
		set_threshold(REG_THR_MODE, SENSE_MAX - SENSE_BITS'(1));
		gaps_on = 1'b1;
		repeat (175) send_tick(random_tick());
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		sense_ch.valid   = 1'b0;
		sense_ch.payload = '0;
		error_count      = 0;
		gaps_on          = 1'b0;
		burst_left       = 0;
		for (int i = 0; i < NUM_THR; i++)
			thr_model[i] = THR_RESET;
		for (int k = 0; k < 2; k++) begin
			key_model[k]   = '0;
			press_left[k]  = 0;
			press_touch[k] = 1'b1;
		end
		teach_model    = 1'b0;
		run_model      = 1'b0;
		cw_cnt_model   = '0;
		ccw_cnt_model  = '0;
		idle_cnt_model = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_threshold_edges();
		test_press_qualification();
		test_random_traffic();
		test_back_to_back();
		test_extreme_thresholds();
		drain_pipeline();

		if (error_count == 0 && pending_ctrl_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/tkrm_pkg.sv
sv/tkrm_if.sv
sv/touch_key_run_mode_control_core.sv
bench/tb.sv
